[hw/rtl/dra_pkg.sv]
package dra_pkg;

    // largest screen side honored for clipping and full-screen merges
    localparam int MAX_SIDE = 4096;

    // field widths
    localparam int MODE_W  = 2;
    localparam int COORD_W = 16;
    localparam int CFG_W   = 13;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int IDX_W   = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TAKE = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // clipped request as it leaves the clip stage
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              hit;
        logic [CFG_W-1:0]  left;
        logic [CFG_W-1:0]  top;
        logic [CFG_W-1:0]  width;
        logic [CFG_W-1:0]  height;
    } clip_t;

endpackage

[hw/rtl/dra_req_if.sv]
interface dra_req_if;
    import dra_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [COORD_W-1:0] req_x;
    logic signed [COORD_W-1:0] req_y;
    logic signed [COORD_W-1:0] req_width;
    logic signed [COORD_W-1:0] req_height;

    modport source (
        output valid, mode, req_x, req_y, req_width, req_height,
        input  ready
    );
    modport sink (
        input  valid, mode, req_x, req_y, req_width, req_height,
        output ready
    );
endinterface

[hw/rtl/dra_rsp_if.sv]
interface dra_rsp_if;
    import dra_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic              region_valid;
    logic [POS_W-1:0]  region_x;
    logic [POS_W-1:0]  region_y;
    logic [SIZE_W-1:0] region_width;
    logic [SIZE_W-1:0] region_height;

    modport source (
        output valid, accepted, region_valid, region_x, region_y,
               region_width, region_height,
        input  ready
    );
    modport sink (
        input  valid, accepted, region_valid, region_x, region_y,
               region_width, region_height,
        output ready
    );
endinterface

[hw/rtl/dra_cfg_if.sv]
interface dra_cfg_if;
    import dra_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] data;

    modport source (
        output valid, reg_index, data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, data,
        output ready
    );
endinterface

[hw/rtl/dirty_region_accumulator_top.sv]
// Dirty-region accumulator: keeps one pending repaint rectangle for a screen
// of configurable size. Each request (add, full screen, take) yields exactly
// one result, presented on rsp from the result register; a new request can
// be taken every cycle unless rsp back-pressure stalls the pipeline: requests
// pass an input register, a clip stage and a merge stage, and the merge stage
// reads and updates the pending rectangle in the same cycle, so back-to-back
// requests see each other's merges with no extra delay. The user must write
// screen sizes through the config channel only while the block is idle; the
// block itself does not enforce this. Sides above MAX_SIDE are treated as
// MAX_SIDE.
module dirty_region_accumulator_top (
    input  logic clk,
    input  logic rst_n,
    dra_req_if.sink   req,
    dra_rsp_if.source rsp,
    dra_cfg_if.sink   cfg
);
    import dra_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] scr_w_reg;
    logic [CFG_W-1:0] scr_h_reg;

    // input register
    logic                      s1_valid_reg;
    logic [MODE_W-1:0]         s1_mode_reg;
    logic signed [COORD_W-1:0] s1_x_reg;
    logic signed [COORD_W-1:0] s1_y_reg;
    logic signed [COORD_W-1:0] s1_w_reg;
    logic signed [COORD_W-1:0] s1_h_reg;

    // clip stage register
    logic  s2_valid_reg;
    clip_t s2_reg;
    clip_t s2_next;

    // pending rectangle
    logic             pend_valid_reg;
    logic [CFG_W-1:0] pend_left_reg;
    logic [CFG_W-1:0] pend_top_reg;
    logic [CFG_W-1:0] pend_width_reg;
    logic [CFG_W-1:0] pend_height_reg;

    // result register
    logic              out_valid_reg;
    logic              out_acc_reg;
    logic              out_rv_reg;
    logic [POS_W-1:0]  out_x_reg;
    logic [POS_W-1:0]  out_y_reg;
    logic [SIZE_W-1:0] out_w_reg;
    logic [SIZE_W-1:0] out_h_reg;

    // stage handshakes
    logic out_free;
    logic s2_ready;
    logic s1_ready;
    logic s2_move;

    assign out_free = !out_valid_reg || rsp.ready;
    assign s2_ready = !s2_valid_reg || out_free;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_move  = s2_valid_reg && out_free;

    assign req.ready = s1_ready;
    assign cfg.ready = 1'b1;

    // config writes, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= CFG_W'(240);
            scr_h_reg <= CFG_W'(320);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg.data;
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // effective screen size
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_h;
    logic             dims_ok;

    assign eff_w   = (32'(scr_w_reg) > 32'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : scr_w_reg;
    assign eff_h   = (32'(scr_h_reg) > 32'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : scr_h_reg;
    assign dims_ok = (eff_w != '0) && (eff_h != '0);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_mode_reg <= req.mode;
            s1_x_reg    <= req.req_x;
            s1_y_reg    <= req.req_y;
            s1_w_reg    <= req.req_width;
            s1_h_reg    <= req.req_height;
        end
    end

    // clip the request to the screen
    logic signed [COORD_W+1:0] xs, ys, rgt, bot, rgt_c, bot_c, lft, tp, sw_s, sh_s;
    logic                      add_hit;

    always_comb
    begin
        xs    = (COORD_W+2)'(s1_x_reg);
        ys    = (COORD_W+2)'(s1_y_reg);
        sw_s  = signed'((COORD_W+2)'(eff_w));
        sh_s  = signed'((COORD_W+2)'(eff_h));
        rgt   = xs + (COORD_W+2)'(s1_w_reg);
        bot   = ys + (COORD_W+2)'(s1_h_reg);
        lft   = s1_x_reg[COORD_W-1] ? '0 : xs;
        tp    = s1_y_reg[COORD_W-1] ? '0 : ys;
        rgt_c = (rgt > sw_s) ? sw_s : rgt;
        bot_c = (bot > sh_s) ? sh_s : bot;
        add_hit = dims_ok && (s1_w_reg > 0) && (s1_h_reg > 0)
                  && (rgt_c > lft) && (bot_c > tp);

        s2_next.mode   = s1_mode_reg;
        s2_next.hit    = 1'b0;
        s2_next.left   = '0;
        s2_next.top    = '0;
        s2_next.width  = '0;
        s2_next.height = '0;
        unique case (s1_mode_reg)
            MODE_ADD:
            begin
                s2_next.hit    = add_hit;
                s2_next.left   = lft[CFG_W-1:0];
                s2_next.top    = tp[CFG_W-1:0];
                s2_next.width  = CFG_W'(rgt_c - lft);
                s2_next.height = CFG_W'(bot_c - tp);
            end
            MODE_FULL:
            begin
                s2_next.hit    = dims_ok;
                s2_next.width  = eff_w;
                s2_next.height = eff_h;
            end
            default: ;
        endcase
    end

    // clip stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    // bounding-box union with the pending rectangle
    logic [CFG_W:0]   new_r, old_r, max_r;
    logic [CFG_W-1:0] min_l, min_t;
    logic [CFG_W:0]   new_b, old_b, max_b;
    logic             mrg_valid;
    logic [CFG_W-1:0] mrg_left, mrg_top, mrg_width, mrg_height;

    always_comb
    begin
        new_r = (CFG_W+1)'(s2_reg.left) + (CFG_W+1)'(s2_reg.width);
        old_r = (CFG_W+1)'(pend_left_reg) + (CFG_W+1)'(pend_width_reg);
        new_b = (CFG_W+1)'(s2_reg.top) + (CFG_W+1)'(s2_reg.height);
        old_b = (CFG_W+1)'(pend_top_reg) + (CFG_W+1)'(pend_height_reg);
        min_l = (s2_reg.left < pend_left_reg) ? s2_reg.left : pend_left_reg;
        min_t = (s2_reg.top < pend_top_reg) ? s2_reg.top : pend_top_reg;
        max_r = (old_r > new_r) ? old_r : new_r;
        max_b = (old_b > new_b) ? old_b : new_b;

        mrg_valid  = pend_valid_reg;
        mrg_left   = pend_left_reg;
        mrg_top    = pend_top_reg;
        mrg_width  = pend_width_reg;
        mrg_height = pend_height_reg;
        if (s2_reg.hit)
        begin
            mrg_valid = 1'b1;
            if (!pend_valid_reg)
            begin
                mrg_left   = s2_reg.left;
                mrg_top    = s2_reg.top;
                mrg_width  = s2_reg.width;
                mrg_height = s2_reg.height;
            end
            else
            begin
                mrg_left   = min_l;
                mrg_top    = min_t;
                mrg_width  = CFG_W'(max_r - (CFG_W+1)'(min_l));
                mrg_height = CFG_W'(max_b - (CFG_W+1)'(min_t));
            end
        end
    end

    // pending rectangle, cleared after a take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_left_reg   <= '0;
            pend_top_reg    <= '0;
            pend_width_reg  <= '0;
            pend_height_reg <= '0;
        end
        else if (s2_move)
        begin
            if (s2_reg.mode == MODE_TAKE)
            begin
                pend_valid_reg  <= 1'b0;
                pend_left_reg   <= '0;
                pend_top_reg    <= '0;
                pend_width_reg  <= '0;
                pend_height_reg <= '0;
            end
            else
            begin
                pend_valid_reg  <= mrg_valid;
                pend_left_reg   <= mrg_left;
                pend_top_reg    <= mrg_top;
                pend_width_reg  <= mrg_width;
                pend_height_reg <= mrg_height;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_acc_reg <= s2_reg.hit;
            out_rv_reg  <= mrg_valid;
            out_x_reg   <= mrg_left[POS_W-1:0];
            out_y_reg   <= mrg_top[POS_W-1:0];
            out_w_reg   <= mrg_width[SIZE_W-1:0];
            out_h_reg   <= mrg_height[SIZE_W-1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.region_valid  = out_rv_reg;
    assign rsp.region_x      = out_x_reg;
    assign rsp.region_y      = out_y_reg;
    assign rsp.region_width  = out_w_reg;
    assign rsp.region_height = out_h_reg;

    // no pending region means an all-zero rectangle
    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_valid_reg |-> (pend_left_reg == '0) && (pend_top_reg == '0)
                            && (pend_width_reg == '0) && (pend_height_reg == '0))
        else $error("pending rectangle not zero while empty");

    // a pending region is never degenerate
    a_region_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_width_reg != '0) && (pend_height_reg != '0))
        else $error("pending rectangle has zero size");

    // a merged request always leaves a region behind
    a_acc_has_region: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> rsp.region_valid)
        else $error("accepted result without a region");

    // a take transfer empties the pending region
    a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_move && (s2_reg.mode == MODE_TAKE)) |=> !pend_valid_reg)
        else $error("take did not clear the pending region");

endmodule

[bench/dirty_region_accumulator_top_tb.sv]
module dirty_region_accumulator_top_tb;
    import dra_pkg::*;

    // the package names no code for the unused mode
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 21;
    localparam int MAX_REPORTS = 100;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        logic [MODE_W-1:0]         mode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
    } rect_req_t;

    typedef struct {
        logic              accepted;
        logic              region_valid;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } region_rsp_t;

    logic clk;
    logic rst_n;

    dra_req_if req_bus ();
    dra_rsp_if rsp_bus ();
    dra_cfg_if cfg_bus ();

    dirty_region_accumulator_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (cfg_bus)
    );

    rect_req_t   pending_reqs[$];
    region_rsp_t expected_regions[$];
    rect_req_t   seen_req;
    rect_req_t   next_req;
    region_rsp_t got_region;
    region_rsp_t want_region;

    // shadow of the screen size and the pending rectangle
    int screen_w_cfg = 240;
    int screen_h_cfg = 320;
    bit region_open  = 0;
    int region_left  = 0;
    int region_top   = 0;
    int region_w     = 0;
    int region_h     = 0;

    bit calm        = 0;
    int errors      = 0;
    int idle_cycles = 0;

    // screen sizes per phase; a negative side asks for a random value for that side
    int phase_w[NUM_PHASES]     = '{1, 4096, 8191, 0, 300, 640, 4097, 13, -1, 240};
    int phase_h[NUM_PHASES]     = '{1, 4096, 8191, 200, 0, 480, 17, 4096, -1, 320};
    int phase_items[NUM_PHASES] = '{60, 250, 150, 50, 50, 300, 120, 120, 200, 100};

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // bounding-box union into the pending rectangle
    function automatic void union_shadow(int l, int t, int w, int h);
        int r;
        int b;
        if (!region_open)
        begin
            region_open = 1;
            region_left = l;
            region_top  = t;
            region_w    = w;
            region_h    = h;
            return;
        end
        r = l + w;
        b = t + h;
        if (region_left + region_w > r) r = region_left + region_w;
        if (region_top + region_h > b) b = region_top + region_h;
        if (l < region_left) region_left = l;
        if (t < region_top) region_top = t;
        region_w = r - region_left;
        region_h = b - region_top;
    endfunction

    // expected result of one request; advances the shadow state
    function automatic region_rsp_t apply_request(rect_req_t r);
        int sw;
        int sh;
        int left;
        int top;
        int right;
        int bottom;
        bit hit;
        region_rsp_t res;
        sw  = (screen_w_cfg > MAX_SIDE) ? MAX_SIDE : screen_w_cfg;
        sh  = (screen_h_cfg > MAX_SIDE) ? MAX_SIDE : screen_h_cfg;
        hit = 0;
        if (r.mode == MODE_ADD)
        begin
            if (sw != 0 && sh != 0 && int'(r.w) > 0 && int'(r.h) > 0)
            begin
                left   = (int'(r.x) > 0) ? int'(r.x) : 0;
                top    = (int'(r.y) > 0) ? int'(r.y) : 0;
                right  = int'(r.x) + int'(r.w);
                bottom = int'(r.y) + int'(r.h);
                if (right > sw) right = sw;
                if (bottom > sh) bottom = sh;
                if (right > left && bottom > top)
                begin
                    union_shadow(left, top, right - left, bottom - top);
                    hit = 1;
                end
            end
        end
        else if (r.mode == MODE_FULL)
        begin
            if (sw != 0 && sh != 0)
            begin
                union_shadow(0, 0, sw, sh);
                hit = 1;
            end
        end
        res.accepted     = hit;
        res.region_valid = region_open;
        res.x = region_open ? POS_W'(region_left) : '0;
        res.y = region_open ? POS_W'(region_top) : '0;
        res.w = region_open ? SIZE_W'(region_w) : '0;
        res.h = region_open ? SIZE_W'(region_h) : '0;
        if (r.mode == MODE_TAKE)
        begin
            region_open = 0;
            region_left = 0;
            region_top  = 0;
            region_w    = 0;
            region_h    = 0;
        end
        return res;
    endfunction

    function automatic void push_req(logic [MODE_W-1:0] mode, int x, int y, int w, int h);
        rect_req_t r;
        r.mode = mode;
        r.x    = COORD_W'(x);
        r.y    = COORD_W'(y);
        r.w    = COORD_W'(w);
        r.h    = COORD_W'(h);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic int pick_coord(int span);
        case ($urandom_range(9))
            0: return int'($urandom) & 16'hFFFF;
            1: return -int'($urandom_range(1, span));
            2: return $urandom_range(0, span + span / 4);
            default: return $urandom_range(0, span - 1);
        endcase
    endfunction

    function automatic int pick_size(int span);
        case ($urandom_range(9))
            0: return int'($urandom) & 16'hFFFF;
            1: return -int'($urandom_range(0, 40));
            2: return $urandom_range(span, 2 * span);
            default: return $urandom_range(1, span / 3 + 1);
        endcase
    endfunction

    // mostly adds sized to the screen, with takes, full merges and a few no-ops
    function automatic void push_random(int sw, int sh);
        int roll;
        int spx;
        int spy;
        logic [MODE_W-1:0] mode;
        spx  = (sw > MAX_SIDE) ? MAX_SIDE : ((sw == 0) ? 64 : sw);
        spy  = (sh > MAX_SIDE) ? MAX_SIDE : ((sh == 0) ? 64 : sh);
        roll = $urandom_range(99);
        if (roll < 62)
            mode = MODE_ADD;
        else if (roll < 72)
            mode = MODE_FULL;
        else if (roll < 96)
            mode = MODE_TAKE;
        else
            mode = MODE_NONE;
        push_req(mode, pick_coord(spx), pick_coord(spy), pick_size(spx), pick_size(spy));
    endfunction

    // both screen registers through the config channel, block idle
    task automatic set_screen(int w, int h);
        @(posedge clk);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= REG_SCREEN_WIDTH;
        cfg_bus.data      <= CFG_W'(w);
        do @(posedge clk); while (!cfg_bus.ready);
        screen_w_cfg       = w & 16'h1FFF;
        cfg_bus.reg_index <= REG_SCREEN_HEIGHT;
        cfg_bus.data      <= CFG_W'(h);
        do @(posedge clk); while (!cfg_bus.ready);
        screen_h_cfg   = h & 16'h1FFF;
        cfg_bus.valid <= 1'b0;
    endtask

    // hold off until every request is sent and every result is back
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_reqs.size() != 0 || req_bus.valid || expected_regions.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // request driver: holds each item until its transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                seen_req.mode = req_bus.mode;
                seen_req.x    = req_bus.req_x;
                seen_req.y    = req_bus.req_y;
                seen_req.w    = req_bus.req_width;
                seen_req.h    = req_bus.req_height;
                expected_regions.insert(expected_regions.size(), apply_request(seen_req));
            end
            if (!req_bus.valid || req_bus.ready)
            begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_req = pending_reqs[0];
                    pending_reqs.delete(0);
                    req_bus.valid      <= 1'b1;
                    req_bus.mode       <= next_req.mode;
                    req_bus.req_x      <= next_req.x;
                    req_bus.req_y      <= next_req.y;
                    req_bus.req_width  <= next_req.w;
                    req_bus.req_height <= next_req.h;
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got_region.accepted     = rsp_bus.accepted;
                got_region.region_valid = rsp_bus.region_valid;
                got_region.x            = rsp_bus.region_x;
                got_region.y            = rsp_bus.region_y;
                got_region.w            = rsp_bus.region_width;
                got_region.h            = rsp_bus.region_height;
                if (expected_regions.size() == 0)
                begin
                    errors++;
                    $display("%0t: result transfer with no request outstanding", $time);
                end
                else
                begin
                    want_region = expected_regions[0];
                    expected_regions.delete(0);
                    check_field("accepted", want_region.accepted, got_region.accepted);
                    check_field("region_valid", want_region.region_valid,
                                got_region.region_valid);
                    check_field("region_x", want_region.x, got_region.x);
                    check_field("region_y", want_region.y, got_region.y);
                    check_field("region_width", want_region.w, got_region.w);
                    check_field("region_height", want_region.h, got_region.h);
                end
            end
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int w;
        int h;
        req_bus.valid      = 1'b0;
        req_bus.mode       = MODE_ADD;
        req_bus.req_x      = '0;
        req_bus.req_y      = '0;
        req_bus.req_width  = '0;
        req_bus.req_height = '0;
        rsp_bus.ready      = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.reg_index  = REG_SCREEN_WIDTH;
        cfg_bus.data       = '0;
        rst_n              = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed part on the reset screen of 240 x 320
        push_req(MODE_TAKE, 0, 0, 0, 0);                          // take with nothing pending
        push_req(MODE_NONE, 1, 2, 3, 4);                          // unused mode
        push_req(MODE_ADD, 10, 20, 0, 5);                         // zero width
        push_req(MODE_ADD, 10, 20, 5, -1);                        // negative height
        push_req(MODE_ADD, 240, 0, 10, 10);                       // past right edge
        push_req(MODE_ADD, 0, 320, 10, 10);                       // past bottom edge
        push_req(MODE_ADD, -100, 0, 50, 10);                      // left of screen
        push_req(MODE_ADD, -32768, -32768, 32767, 32767);
        push_req(MODE_ADD, 32767, 32767, 32767, 32767);
        push_req(MODE_ADD, -32768, 0, -32768, 10);
        push_req(MODE_ADD, 10, 20, 30, 40);                       // first merge
        push_req(MODE_ADD, -5, -5, 10, 10);                       // clipped at top left
        push_req(MODE_ADD, 200, 300, 100, 100);                   // clipped at bottom right
        push_req(MODE_TAKE, -1, -1, -1, -1);
        push_req(MODE_TAKE, 0, 0, 0, 0);
        push_req(MODE_ADD, 0, 0, 1, 1);
        push_req(MODE_ADD, 239, 319, 1, 1);                       // corners span the screen
        push_req(MODE_FULL, -1, -1, -1, -1);                      // full ignores the fields
        push_req(MODE_TAKE, 32767, 32767, 32767, 32767);
        push_req(MODE_ADD, 5, 5, 5, 5);
        push_req(MODE_NONE, -32768, -32768, -32768, -32768);      // no-op keeps the region
        push_req(MODE_FULL, 0, 0, 0, 0);
        push_req(MODE_TAKE, 0, 0, 0, 0);
        push_req(MODE_ADD, -1, -1, 32767, 32767);                 // covers the whole screen
        push_req(MODE_TAKE, 0, 0, 0, 0);
        wait_drained();

        // random phases over a range of screen sizes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            w = (phase_w[p] < 0) ? $urandom_range(1, 1500) : phase_w[p];
            h = (phase_h[p] < 0) ? $urandom_range(1, 1500) : phase_h[p];
            set_screen(w, h);
            calm = (p == 5);
            for (int i = 0; i < phase_items[p] / 2; i++)
                push_random(w, h);
            // sender pauses until every result is back
            wait_drained();
            for (int i = phase_items[p] / 2; i < phase_items[p]; i++)
                push_random(w, h);
            // sometimes leave a full region pending when the next screen size is set
            if ($urandom_range(1) == 1)
                push_req(MODE_FULL, 0, 0, 0, 0);
            wait_drained();
        end
        calm = 0;
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dra_pkg.sv
hw/rtl/dra_req_if.sv
hw/rtl/dra_rsp_if.sv
hw/rtl/dra_cfg_if.sv
hw/rtl/dirty_region_accumulator_top.sv
bench/dirty_region_accumulator_top_tb.sv
